### hw/rtl/assert_macros.svh
// assertion macros shared by the ring manager modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked assertion, disabled while reset is low
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`endif

### hw/rtl/pdrm_pkg.sv
// shared types and constants of the packet descriptor ring manager
package pdrm_pkg;

  localparam int MaxSlotsDef = 16;
  localparam int MaxBytes    = 65536;

  localparam logic [16:0] TOTAL_RESET = 17'd65536;
  localparam logic [4:0]  SLOTS_RESET = 5'd16;

  localparam logic CFG_TOTAL_BYTES = 1'b0;
  localparam logic CFG_SLOT_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_SYNC  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_FULL     = 3'd2,
    ST_SEQ_MISS = 3'd3,
    ST_SMALL    = 3'd4,
    ST_NO_SYNC  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_RD,
    S_EXEC,
    S_SYNC_RD,
    S_SYNC_CHK
  } state_e;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] off;
    logic [16:0] size;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic scan_step;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e in_cmd;
    logic in_bad_len;
    logic mod_done;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

### hw/rtl/pdrm_ctrl.sv
// controller state machine sequencing slot modulo, table read, scan and update
`include "assert_macros.svh"
module pdrm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pdrm_pkg::dp_status_t  status_i,
  output pdrm_pkg::ctrl_cmd_t   cmd_o
);
  import pdrm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          priority if (status_i.in_bad_len) state_d = S_EXEC;
          else if (status_i.in_cmd == CMD_SYNC) state_d = S_SYNC_RD;
          else state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (status_i.mod_done) state_d = S_RD;
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_SYNC_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SYNC_CHK;
      end
      S_SYNC_CHK: begin
        if (status_i.scan_done) begin
          if (status_i.out_free) begin
            cmd_o.exec = 1'b1;
            state_d    = S_IDLE;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d         = S_SYNC_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `ASSERT_CLK(a_exec_returns_idle, cmd_o.exec |=> state_q == S_IDLE, "exec did not end the item")
  `ASSERT_CLK(a_mod_then_read, (state_q == S_MOD) && status_i.mod_done |=> cmd_o.rd_en,
      "table read did not follow modulo")
  `ASSERT_CLK(a_exec_needs_free, cmd_o.exec |-> status_i.out_free, "result overwrote a beat")

endmodule

### hw/rtl/pdrm_dpath.sv
// datapath: config registers, ring state, descriptor table, modulo unit, result register
`include "assert_macros.svh"
module pdrm_dpath #(
  parameter int MAX_SLOTS = pdrm_pkg::MaxSlotsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [16:0]          cfg_data_i,
  input  logic [1:0]           cmd_i,
  input  logic [16:0]          length_i,
  input  logic [7:0]           read_slot_i,
  input  logic [31:0]          expected_seq_i,
  input  pdrm_pkg::ctrl_cmd_t  ctrl_i,
  output pdrm_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_res_o,
  output logic                 valid_res_o,
  output logic [15:0]          first_offset_o,
  output logic [16:0]          first_len_o,
  output logic [16:0]          second_len_o,
  output logic [7:0]           slot_index_o,
  output logic [31:0]          seq_out_o
);
  import pdrm_pkg::*;

  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  // configuration
  logic [16:0] total_q;
  logic [4:0]  slots_q;
  logic [16:0] te;
  logic [4:0]  n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RESET;
      slots_q <= SLOTS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TOTAL_BYTES: total_q <= cfg_data_i;
        CFG_SLOT_COUNT:  slots_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (total_q == 17'd0) te = 17'd1;
    else if (32'(total_q) > MaxBytes) te = 17'(MaxBytes);
    else te = total_q;
    priority if (slots_q == 5'd0) n = 5'd1;
    else if (32'(slots_q) > MAX_SLOTS) n = 5'(MAX_SLOTS);
    else n = slots_q;
  end

  // latched item
  cmd_e        cmd_q;
  logic [16:0] len_q;
  logic [7:0]  rslot_q;
  logic [31:0] exp_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q   <= cmd_e'(cmd_i);
      len_q   <= length_i;
      rslot_q <= read_slot_i;
      exp_q   <= expected_seq_i;
    end
  end

  // ring state
  logic [31:0] wseq_q, wseq_d;
  logic [15:0] wo_q, wo_d;
  logic [16:0] used_q, used_d;

  // restoring modulo, one dividend bit a cycle
  logic [31:0] div_q;
  logic [5:0]  cnt_q;
  logic [4:0]  rem_q;
  logic [5:0]  trial;

  assign trial = {rem_q, div_q[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.accept) begin
      unique case (cmd_e'(cmd_i))
        CMD_READ:  cnt_q <= 6'd8;
        CMD_SYNC:  cnt_q <= 6'd0;
        default:   cnt_q <= 6'd32;
      endcase
    end else if (cnt_q != 6'd0) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      div_q <= (cmd_e'(cmd_i) == CMD_READ) ? {read_slot_i, 24'd0} : wseq_q;
      rem_q <= '0;
    end else if (cnt_q != 6'd0) begin
      div_q <= {div_q[30:0], 1'b0};
      rem_q <= (trial >= {1'b0, n}) ? 5'(trial - {1'b0, n}) : trial[4:0];
    end
  end

  // descriptor table with per-slot valid bits; invalid slots read as zero
  entry_t          mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] slot_vld_q;
  entry_t          ent_q;
  logic            ent_vld_q;
  entry_t          e;
  logic [4:0]      scan_idx_q;
  logic [SW-1:0]   rd_addr;
  logic [SW-1:0]   wr_addr;
  logic            mem_we;
  entry_t          wr_ent;

  assign rd_addr = (cmd_q == CMD_SYNC) ? SW'(scan_idx_q) : SW'(rem_q);
  assign wr_addr = SW'(rem_q);
  assign e       = ent_vld_q ? ent_q : '0;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      ent_q     <= mem[rd_addr];
      ent_vld_q <= slot_vld_q[rd_addr];
    end
    if (mem_we) begin
      mem[wr_addr] <= wr_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
    end else if (mem_we) begin
      slot_vld_q[wr_addr] <= 1'b1;
    end
  end

  // sync scan
  logic [7:0]  run_q, run_n;
  logic [31:0] last_q, last_n;
  logic [4:0]  nidx;
  logic        first, brk;

  assign first = (scan_idx_q == 5'd0);
  assign brk   = first ? (e.size == 17'd0)
                       : ((e.size == 17'd0) || (e.seq != last_q + 32'd1));
  assign nidx  = scan_idx_q + 5'd1;
  assign run_n  = first ? 8'd0 : run_q + 8'd1;
  assign last_n = first ? e.seq : last_q + 32'd1;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      scan_idx_q <= '0;
    end else if (ctrl_i.scan_step) begin
      scan_idx_q <= nidx;
      run_q      <= run_n;
      last_q     <= last_n;
    end
  end

  // result and update
  logic        bad_q;
  logic [16:0] freed;
  logic [17:0] need;
  logic [15:0] off;
  logic [17:0] wend, rend;
  status_e     r_st;
  logic        r_vld;
  logic [15:0] r_foff;
  logic [16:0] r_flen, r_slen;
  logic [7:0]  r_sidx;
  logic [31:0] r_sq;

  assign bad_q = (len_q == 17'd0) && ((cmd_q == CMD_WRITE) || (cmd_q == CMD_READ));
  assign freed = (e.size == 17'd0) ? used_q
               : ((used_q >= e.size) ? used_q - e.size : 17'd0);
  assign need  = {1'b0, freed} + {1'b0, len_q};
  assign off   = ({1'b0, wo_q} < te) ? wo_q : 16'd0;
  assign wend  = {2'b0, off} + {1'b0, len_q};
  assign rend  = {2'b0, e.off} + {1'b0, e.size};

  always_comb begin
    r_st   = ST_OK;
    r_vld  = 1'b0;
    r_foff = '0;
    r_flen = '0;
    r_slen = '0;
    r_sidx = '0;
    r_sq   = '0;
    wseq_d = wseq_q;
    wo_d   = wo_q;
    used_d = used_q;
    mem_we = 1'b0;
    wr_ent = e;
    if (bad_q) begin
      r_st = ST_BAD_LEN;
    end else begin
      unique case (cmd_q)
        CMD_WRITE: begin
          mem_we      = 1'b1;
          wr_ent.size = '0;
          used_d      = freed;
          if (need > {1'b0, te}) begin
            r_st = ST_FULL;
          end else begin
            wr_ent = '{seq: wseq_q, off: off, size: len_q};
            r_foff = off;
            if (wend > {1'b0, te}) begin
              r_flen = te - {1'b0, off};
              r_slen = len_q - r_flen;
              wo_d   = r_slen[15:0];
            end else begin
              r_flen = len_q;
              wo_d   = (wend >= {1'b0, te}) ? 16'd0 : wend[15:0];
            end
            used_d = 17'(need);
            r_vld  = 1'b1;
            r_sidx = 8'(rem_q);
            r_sq   = wseq_q;
            wseq_d = wseq_q + 32'd1;
          end
        end
        CMD_READ: begin
          if (e.size != 17'd0) begin
            priority if (len_q < e.size) begin
              r_st = ST_SMALL;
            end else if (exp_q != e.seq) begin
              r_st = ST_SEQ_MISS;
            end else begin
              r_vld  = 1'b1;
              r_foff = e.off;
              if (rend > {1'b0, te}) begin
                r_flen = ({1'b0, e.off} < te) ? te - {1'b0, e.off} : 17'd0;
                r_slen = e.size - r_flen;
              end else begin
                r_flen = e.size;
              end
              r_sidx = 8'(rem_q) + 8'd1;
              r_sq   = exp_q + 32'd1;
            end
          end
        end
        CMD_SYNC: begin
          if (first && brk) begin
            r_st = ST_NO_SYNC;
          end else begin
            r_vld  = 1'b1;
            r_sidx = brk ? run_q : run_n;
            r_sq   = brk ? last_q : last_n;
          end
        end
        CMD_QUERY: begin
          r_sidx = 8'(rem_q);
          r_sq   = e.seq;
        end
        default: ;
      endcase
    end
    if (!ctrl_i.exec) begin
      mem_we = 1'b0;
    end
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wseq_q      <= '0;
      wo_q        <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.exec) begin
        wseq_q <= wseq_d;
        wo_q   <= wo_d;
        used_q <= used_d;
      end
      if (ctrl_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      status_res_o   <= r_st;
      valid_res_o    <= r_vld;
      first_offset_o <= r_foff;
      first_len_o    <= r_flen;
      second_len_o   <= r_slen;
      slot_index_o   <= r_sidx;
      seq_out_o      <= r_sq;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o.in_cmd      = cmd_e'(cmd_i);
  assign status_o.in_bad_len  = (length_i == 17'd0)
                              && ((cmd_e'(cmd_i) == CMD_WRITE) || (cmd_e'(cmd_i) == CMD_READ));
  assign status_o.mod_done    = (cnt_q == 6'd0);
  assign status_o.scan_done   = brk || (nidx >= n);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  `ASSERT_CLK(a_div_counts_down, cnt_q != 6'd0 && !ctrl_i.accept |=> cnt_q == $past(cnt_q) - 6'd1,
      "modulo counter skipped")
  `ASSERT_CLK(a_seq_only_on_exec, !ctrl_i.exec |=> $stable(wseq_q), "write sequence moved idle")
  `ASSERT_CLK(a_div_idle_holds, cnt_q == 6'd0 && !ctrl_i.accept |=> cnt_q == 6'd0,
      "modulo restarted without an item")

endmodule

### hw/rtl/packet_descriptor_ring_manager.sv
// write and query: 32-step slot modulo, table read, update; read: slot modulo, table read,
// update; bad length: update only; sync: one table read and compare per slot
// throughput: one item at a time; next item accepted once the result is registered
// the finished beat waits in the output register while the next item runs
// reset: ring state, descriptor valid bits and handshake clear at once; no clearing pass
// config resets to a 65536-byte ring and 16 slots
module packet_descriptor_ring_manager #(
  parameter int MAX_SLOTS = pdrm_pkg::MaxSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [16:0] length_i,
  input  logic [7:0]  read_slot_i,
  input  logic [31:0] expected_seq_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        valid_res_o,
  output logic [15:0] first_offset_o,
  output logic [16:0] first_len_o,
  output logic [16:0] second_len_o,
  output logic [7:0]  slot_index_o,
  output logic [31:0] seq_out_o
);
  import pdrm_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t dp_st;

  pdrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_st),
    .cmd_o      (ctrl)
  );

  pdrm_dpath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd_i),
    .length_i       (length_i),
    .read_slot_i    (read_slot_i),
    .expected_seq_i (expected_seq_i),
    .ctrl_i         (ctrl),
    .status_o       (dp_st),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_res_o   (status_o),
    .valid_res_o    (valid_res_o),
    .first_offset_o (first_offset_o),
    .first_len_o    (first_len_o),
    .second_len_o   (second_len_o),
    .slot_index_o   (slot_index_o),
    .seq_out_o      (seq_out_o)
  );

endmodule
